// ===== src/hcfd_pkg.sv =====
// Shared types and constants for the Hermite curve forward-difference block.
// Used by the front end, the segment queue, the walker and the top level.
package hcfd_pkg;

    // Input coordinate width and result coordinate width.
    localparam int COORD_W = 10;
    localparam int OUT_W   = 13;

    // Width of the fixed point difference accumulators.
    localparam int ACC_W = 32;

    // Depth of the segment queue between front end and walker.
    localparam int QUEUE_DEPTH = 2;

    // Start values of the forward differences for one axis.
    typedef struct packed {
        logic signed [ACC_W-1:0] pos;
        logic signed [ACC_W-1:0] d1;
        logic signed [ACC_W-1:0] d2;
        logic signed [ACC_W-1:0] d3;
    } axis_cmd_t;

    // One segment to walk; last marks the final segment caused by an item.
    typedef struct packed {
        axis_cmd_t x;
        axis_cmd_t y;
        logic      last;
    } seg_cmd_t;

    // A segment offered to the queue.
    typedef struct packed {
        logic     valid;
        seg_cmd_t cmd;
    } seg_push_t;

endpackage

// ===== src/hermite_curve_forward_difference.sv =====
// Top level of the Hermite curve forward-difference block.
// Instantiates hcfd_front, hcfd_queue and hcfd_back; uses hcfd_pkg.
//
// Each item carries an anchor and its tangent handle; the chain of anchors
// is closed by the item marked last_pair. Every anchor after the first
// yields one cubic segment of 2^STEP_LOG2+1 points (17 at the default), and
// the last item adds the closing segment back to the first anchor, so such
// an item yields 34 points; the first item of a chain yields none unless it
// is also marked last, when it yields one segment that closes on itself.
// Points leave one per cycle from the walker's output register while the
// receiver is ready, and consecutive segments follow without a gap. A
// two-entry segment queue lets the front end take the next item while the
// walker is still stepping; an item marked last that closes a chain of two
// or more anchors holds off the next item until its closing segment is
// queued, which waits while the queue is full. Coordinates are fixed point with
// 3*STEP_LOG2 fraction bits, rounded half up and saturated.
module hermite_curve_forward_difference
    import hcfd_pkg::*;
#(
    parameter int STEP_LOG2  = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [COORD_W-1:0]      s_anchor_x,
    input  logic [COORD_W-1:0]      s_anchor_y,
    input  logic [COORD_W-1:0]      s_handle_x,
    input  logic [COORD_W-1:0]      s_handle_y,
    input  logic                    s_last_pair,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_point_x,
    output logic signed [OUT_W-1:0] m_point_y,
    output logic                    m_segment_end,
    output logic                    m_is_last
);

    seg_push_t push;
    logic      q_full;
    logic      q_valid;
    seg_cmd_t  q_cmd;
    logic      q_ready;

    // Item intake and segment set-up.
    hcfd_front #(
        .STEP_LOG2  (STEP_LOG2),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_anchor_x  (s_anchor_x),
        .s_anchor_y  (s_anchor_y),
        .s_handle_x  (s_handle_x),
        .s_handle_y  (s_handle_y),
        .s_last_pair (s_last_pair),
        .q_full      (q_full),
        .push        (push)
    );

    // Segments waiting for the walker.
    hcfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd),
        .pop_ready (q_ready)
    );

    // Forward-difference walker and output register.
    hcfd_back #(
        .STEP_LOG2 (STEP_LOG2)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd           (q_cmd),
        .cmd_ready     (q_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_segment_end (m_segment_end),
        .m_is_last     (m_is_last)
    );

endmodule

// ===== src/hcfd_front.sv =====
// Front end: accepts anchor/handle items, keeps the chain state and turns
// each segment into forward difference start values. Uses hcfd_pkg.
module hcfd_front
    import hcfd_pkg::*;
#(
    parameter int STEP_LOG2  = 4,
    parameter int COORD_BITS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_anchor_x,
    input  logic [COORD_W-1:0] s_anchor_y,
    input  logic [COORD_W-1:0] s_handle_x,
    input  logic [COORD_W-1:0] s_handle_y,
    input  logic               s_last_pair,
    input  logic               q_full,
    output seg_push_t          push
);

    localparam int FRAC_BITS = 3 * STEP_LOG2;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

    logic [COORD_W-1:0] first_ax_reg, first_ay_reg, first_hx_reg, first_hy_reg;
    logic [COORD_W-1:0] prev_ax_reg, prev_ay_reg, prev_hx_reg, prev_hy_reg;
    logic               have_first_reg, have_first_next;
    logic               pend_close_reg, pend_close_next;

    logic [COORD_W-1:0] anc_x, anc_y, hnd_x, hnd_y;
    logic               accept;

    // Polynomial coefficients of one axis, turned into difference start values.
    function automatic axis_cmd_t seg_axis(input logic [COORD_W-1:0] p1,
                                           input logic [COORD_W-1:0] h1,
                                           input logic [COORD_W-1:0] p4,
                                           input logic [COORD_W-1:0] h4);
        logic signed [ACC_W-1:0] q1, q4, r1, r4, dq, a, b;
        axis_cmd_t res;
        q1 = $signed(ACC_W'(p1));
        q4 = $signed(ACC_W'(p4));
        r1 = $signed(ACC_W'(h1)) - q1;
        r4 = $signed(ACC_W'(h4)) - q4;
        dq = q4 - q1;
        a = r1 + r4 - (dq <<< 1);
        b = dq + (dq <<< 1) - (r1 <<< 1) - r4;
        res.pos = q1 <<< FRAC_BITS;
        res.d1  = a + (b <<< STEP_LOG2) + (r1 <<< (2 * STEP_LOG2));
        res.d3  = (a <<< 2) + (a <<< 1);
        res.d2  = res.d3 + (b <<< (STEP_LOG2 + 1));
        return res;
    endfunction

    // Coordinates are limited to the configured number of bits.
    assign anc_x = s_anchor_x & COORD_MASK;
    assign anc_y = s_anchor_y & COORD_MASK;
    assign hnd_x = s_handle_x & COORD_MASK;
    assign hnd_y = s_handle_y & COORD_MASK;

    // A closing segment still to be queued holds off the next item.
    assign s_ready = !pend_close_reg && !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the item and build the segment to queue, if any.
    always_comb begin
        push            = '0;
        have_first_next = have_first_reg;
        pend_close_next = pend_close_reg;
        if (pend_close_reg) begin
            push.valid    = !q_full;
            push.cmd.x    = seg_axis(prev_ax_reg, prev_hx_reg, first_ax_reg, first_hx_reg);
            push.cmd.y    = seg_axis(prev_ay_reg, prev_hy_reg, first_ay_reg, first_hy_reg);
            push.cmd.last = 1'b1;
            if (!q_full) begin
                pend_close_next = 1'b0;
            end
        end else if (accept) begin
            if (have_first_reg) begin
                push.valid    = 1'b1;
                push.cmd.x    = seg_axis(prev_ax_reg, prev_hx_reg, anc_x, hnd_x);
                push.cmd.y    = seg_axis(prev_ay_reg, prev_hy_reg, anc_y, hnd_y);
                push.cmd.last = !s_last_pair;
                if (s_last_pair) begin
                    have_first_next = 1'b0;
                    pend_close_next = 1'b1;
                end
            end else if (s_last_pair) begin
                // A chain of one anchor closes on itself.
                push.valid    = 1'b1;
                push.cmd.x    = seg_axis(anc_x, hnd_x, anc_x, hnd_x);
                push.cmd.y    = seg_axis(anc_y, hnd_y, anc_y, hnd_y);
                push.cmd.last = 1'b1;
            end else begin
                have_first_next = 1'b1;
            end
        end
    end

    // Chain control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            pend_close_reg <= 1'b0;
        end else begin
            have_first_reg <= have_first_next;
            pend_close_reg <= pend_close_next;
        end
    end

    // Stored anchors and handles.
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_ax_reg <= anc_x;
            prev_ay_reg <= anc_y;
            prev_hx_reg <= hnd_x;
            prev_hy_reg <= hnd_y;
            if (!have_first_reg) begin
                first_ax_reg <= anc_x;
                first_ay_reg <= anc_y;
                first_hx_reg <= hnd_x;
                first_hy_reg <= hnd_y;
            end
        end
    end

endmodule

// ===== src/hcfd_queue.sv =====
// Short segment queue that decouples the front end from the walker.
// Uses hcfd_pkg for the segment type and the queue depth.
module hcfd_queue
    import hcfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seg_push_t push,
    output logic      full,
    output logic      pop_valid,
    output seg_cmd_t  pop_cmd,
    input  logic      pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    seg_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ===== src/hcfd_back.sv =====
// Walker: steps one segment by forward differencing, one rounded point a
// cycle while the output is not stalled, into an output register. Uses hcfd_pkg.
module hcfd_back
    import hcfd_pkg::*;
#(
    parameter int STEP_LOG2 = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cmd_valid,
    input  seg_cmd_t                cmd,
    output logic                    cmd_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_point_x,
    output logic signed [OUT_W-1:0] m_point_y,
    output logic                    m_segment_end,
    output logic                    m_is_last
);

    localparam int FRAC_BITS = 3 * STEP_LOG2;
    localparam int STEP_W    = STEP_LOG2 + 1;
    localparam logic [STEP_W-1:0]      NSTEPS = STEP_W'(1 << STEP_LOG2);
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);

    axis_cmd_t          x_reg, y_reg;
    logic               last_reg;
    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               m_valid_reg;
    logic signed [OUT_W-1:0] point_x_reg, point_y_reg;
    logic               seg_end_reg, is_last_reg;

    logic advance, at_end, load;

    // Round half up to a whole pixel and saturate to the result range.
    function automatic logic signed [OUT_W-1:0] round_pixel(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        logic fits;
        q = (v + HALF) >>> FRAC_BITS;
        fits = (q[ACC_W-1:OUT_W-1] == '0) || (q[ACC_W-1:OUT_W-1] == '1);
        if (fits) begin
            return q[OUT_W-1:0];
        end else if (q[ACC_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    // One difference step of one axis.
    function automatic axis_cmd_t step_axis(input axis_cmd_t a);
        axis_cmd_t res;
        res.pos = a.pos + a.d1;
        res.d1  = a.d1 + a.d2;
        res.d2  = a.d2 + a.d3;
        res.d3  = a.d3;
        return res;
    endfunction

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign at_end    = (step_reg == NSTEPS);
    assign load      = cmd_valid && (!busy_reg || (advance && at_end));
    assign cmd_ready = load;

    // Walker control and output register handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (advance) begin
                if (at_end) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // Difference accumulators and result payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            point_x_reg <= round_pixel(x_reg.pos);
            point_y_reg <= round_pixel(y_reg.pos);
            seg_end_reg <= at_end;
            is_last_reg <= at_end && last_reg;
        end
        if (load) begin
            x_reg    <= cmd.x;
            y_reg    <= cmd.y;
            last_reg <= cmd.last;
        end else if (advance && !at_end) begin
            x_reg <= step_axis(x_reg);
            y_reg <= step_axis(y_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_x     = point_x_reg;
    assign m_point_y     = point_y_reg;
    assign m_segment_end = seg_end_reg;
    assign m_is_last     = is_last_reg;

endmodule

// ===== verif/hermite_curve_forward_difference_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hermite_curve_forward_difference.
// Drives closed anchor chains, predicts every curve point and checks each result item.
// Depends on hcfd_pkg and the block's RTL only.
module hermite_curve_forward_difference_tb
    import hcfd_pkg::*;
;

    localparam int STEP_LOG2    = 4;
    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 3 * STEP_LOG2;
    localparam int NUM_STEPS    = 1 << STEP_LOG2;
    localparam int PIXEL_MIN    = -(1 << (OUT_W - 1));
    localparam int PIXEL_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;

    // One anchor/handle item as it is offered on the input channel.
    typedef struct {
        logic [COORD_W-1:0] anchor_x;
        logic [COORD_W-1:0] anchor_y;
        logic [COORD_W-1:0] handle_x;
        logic [COORD_W-1:0] handle_y;
        logic               last_pair;
    } anchor_pair_t;

    // One curve point as it leaves the result channel.
    typedef struct {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic                    segment_end;
        logic                    is_last;
    } curve_point_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [COORD_W-1:0]      s_anchor_x  = '0;
    logic [COORD_W-1:0]      s_anchor_y  = '0;
    logic [COORD_W-1:0]      s_handle_x  = '0;
    logic [COORD_W-1:0]      s_handle_y  = '0;
    logic                    s_last_pair = 1'b0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic signed [OUT_W-1:0] m_point_x;
    logic signed [OUT_W-1:0] m_point_y;
    logic                    m_segment_end;
    logic                    m_is_last;

    anchor_pair_t pending_pairs[$];
    curve_point_t expected_points[$];
    anchor_pair_t held_pair;
    anchor_pair_t next_pair;
    int           total_pairs;
    int           pairs_accepted = 0;
    int           error_count    = 0;
    int           cycle_count    = 0;

    // Chain state of the predictor: first pair of the open chain and the latest pair.
    longint chain_first_anchor[2];
    longint chain_first_handle[2];
    longint chain_prior_anchor[2];
    longint chain_prior_handle[2];
    bit     chain_open = 1'b0;

    hermite_curve_forward_difference #(
        .STEP_LOG2  (STEP_LOG2),
        .COORD_BITS (COORD_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_anchor_x    (s_anchor_x),
        .s_anchor_y    (s_anchor_y),
        .s_handle_x    (s_handle_x),
        .s_handle_y    (s_handle_y),
        .s_last_pair   (s_last_pair),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_segment_end (m_segment_end),
        .m_is_last     (m_is_last)
    );

    // Clock and a single reset pulse at the start.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Rounds a fixed point coordinate half up to a whole pixel and saturates it.
    function automatic logic signed [OUT_W-1:0] to_pixel(input longint fixed_val);
        longint pixel;
        pixel = (fixed_val + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (pixel < PIXEL_MIN) pixel = PIXEL_MIN;
        if (pixel > PIXEL_MAX) pixel = PIXEL_MAX;
        return pixel[OUT_W-1:0];
    endfunction

    // Walks one Hermite segment by forward differences and queues its points.
    task automatic walk_hermite_segment(input longint from_anchor[2],
                                        input longint from_handle[2],
                                        input longint to_anchor[2],
                                        input longint to_handle[2],
                                        input bit     ends_item);
        longint       pos[2];
        longint       diff1[2];
        longint       diff2[2];
        longint       diff3[2];
        longint       tan_from;
        longint       tan_to;
        longint       coef_a;
        longint       coef_b;
        curve_point_t pt;
        for (int ax = 0; ax < 2; ax++) begin
            tan_from  = from_handle[ax] - from_anchor[ax];
            tan_to    = to_handle[ax] - to_anchor[ax];
            coef_a    = 2 * from_anchor[ax] - 2 * to_anchor[ax] + tan_from + tan_to;
            coef_b    = -3 * from_anchor[ax] + 3 * to_anchor[ax] - 2 * tan_from - tan_to;
            pos[ax]   = from_anchor[ax] <<< FRAC_BITS;
            diff1[ax] = coef_a + coef_b * NUM_STEPS + tan_from * NUM_STEPS * NUM_STEPS;
            diff2[ax] = 6 * coef_a + 2 * coef_b * NUM_STEPS;
            diff3[ax] = 6 * coef_a;
        end
        for (int step = 0; step <= NUM_STEPS; step++) begin
            pt.point_x     = to_pixel(pos[0]);
            pt.point_y     = to_pixel(pos[1]);
            pt.segment_end = (step == NUM_STEPS);
            pt.is_last     = ends_item && (step == NUM_STEPS);
            expected_points.push_back(pt);
            for (int ax = 0; ax < 2; ax++) begin
                pos[ax]   += diff1[ax];
                diff1[ax] += diff2[ax];
                diff2[ax] += diff3[ax];
            end
        end
    endtask

    // Updates the chain state for one accepted item and queues the points it causes.
    task automatic predict_curve_points(input anchor_pair_t pair);
        longint mask;
        longint anchor[2];
        longint handle[2];
        mask      = (longint'(1) <<< COORD_BITS) - 1;
        anchor[0] = longint'(pair.anchor_x) & mask;
        anchor[1] = longint'(pair.anchor_y) & mask;
        handle[0] = longint'(pair.handle_x) & mask;
        handle[1] = longint'(pair.handle_y) & mask;
        if (!chain_open) begin
            chain_first_anchor = anchor;
            chain_first_handle = handle;
            chain_open         = 1'b1;
        end else begin
            walk_hermite_segment(chain_prior_anchor, chain_prior_handle, anchor, handle,
                                 !pair.last_pair);
        end
        chain_prior_anchor = anchor;
        chain_prior_handle = handle;
        // The item marked last closes the chain back to its first anchor.
        if (pair.last_pair) begin
            walk_hermite_segment(chain_prior_anchor, chain_prior_handle,
                                 chain_first_anchor, chain_first_handle, 1'b1);
            chain_open = 1'b0;
        end
    endtask

    function automatic anchor_pair_t make_pair(input int ax, input int ay, input int hx,
                                               input int hy, input bit last);
        anchor_pair_t pair;
        pair.anchor_x  = ax[COORD_W-1:0];
        pair.anchor_y  = ay[COORD_W-1:0];
        pair.handle_x  = hx[COORD_W-1:0];
        pair.handle_y  = hy[COORD_W-1:0];
        pair.last_pair = last;
        return pair;
    endfunction

    // Coordinates lean towards the edges of the range now and then.
    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 0;
        if (roll < 20) return (1 << COORD_W) - 1;
        return $urandom_range((1 << COORD_W) - 1);
    endfunction

    // Idling percentages for the four phases of the run.
    function automatic int idle_phase();
        return (total_pairs == 0) ? 0 : (pairs_accepted * 4) / total_pairs;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            1: return 72;
            3: return 38;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            2: return 72;
            3: return 38;
            default: return 0;
        endcase
    endfunction

    // Stimulus: directed chains first, then random closed chains, then the final verdict.
    initial begin
        int chain_len;
        int roll;
        // Single-item chains close on themselves.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 1'b1));
        pending_pairs.push_back(make_pair(1023, 1023, 0, 0, 1'b1));
        pending_pairs.push_back(make_pair(0, 1023, 1023, 0, 1'b1));
        // Square of corner anchors with extreme handles.
        pending_pairs.push_back(make_pair(0, 0, 1023, 1023, 1'b0));
        pending_pairs.push_back(make_pair(1023, 0, 0, 1023, 1'b0));
        pending_pairs.push_back(make_pair(1023, 1023, 0, 0, 1'b0));
        pending_pairs.push_back(make_pair(0, 1023, 1023, 0, 1'b1));
        // Two-item chain with the largest opposing tangents.
        pending_pairs.push_back(make_pair(0, 1023, 1023, 1023, 1'b0));
        pending_pairs.push_back(make_pair(1023, 0, 0, 0, 1'b1));
        // Degenerate chain of coincident points and zero tangents.
        pending_pairs.push_back(make_pair(512, 512, 512, 512, 1'b0));
        pending_pairs.push_back(make_pair(512, 512, 512, 512, 1'b1));
        // Alternating bit patterns.
        pending_pairs.push_back(make_pair(682, 341, 341, 682, 1'b0));
        pending_pairs.push_back(make_pair(341, 682, 682, 341, 1'b0));
        pending_pairs.push_back(make_pair(1, 1022, 1022, 1, 1'b1));

        // Random closed chains, mostly of a few anchors, some long ones.
        total_pairs = pending_pairs.size() + RANDOM_ITEMS;
        while (pending_pairs.size() < total_pairs) begin
            roll = $urandom_range(99);
            if (roll < 10)      chain_len = 1;
            else if (roll < 85) chain_len = $urandom_range(2, 5);
            else                chain_len = $urandom_range(6, 16);
            for (int k = 0; k < chain_len; k++) begin
                pending_pairs.push_back(make_pair(pick_coord(), pick_coord(), pick_coord(),
                                                  pick_coord(), k == chain_len - 1));
            end
        end
        total_pairs = pending_pairs.size();

        while (pending_pairs.size() != 0 || s_valid || expected_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: predicts on acceptance and offers the next pending item unless idling.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_curve_points(held_pair);
                pairs_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    next_pair   = pending_pairs.pop_front();
                    held_pair   = next_pair;
                    s_anchor_x  <= next_pair.anchor_x;
                    s_anchor_y  <= next_pair.anchor_y;
                    s_handle_x  <= next_pair.handle_x;
                    s_handle_y  <= next_pair.handle_y;
                    s_last_pair <= next_pair.last_pair;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // Monitor: each accepted point is checked against the oldest expected point.
    always @(posedge aclk) begin
        curve_point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_LIMIT)
                    $display("%0t: unexpected point: expected none, actual x=%0d y=%0d",
                             $time, m_point_x, m_point_y);
            end else begin
                want = expected_points.pop_front();
                if (m_point_x !== want.point_x || m_point_y !== want.point_y ||
                    m_segment_end !== want.segment_end || m_is_last !== want.is_last) begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                        $display({"%0t: point mismatch: expected x=%0d y=%0d end=%0b ",
                                  "last=%0b, actual x=%0d y=%0d end=%0b last=%0b"},
                                 $time, want.point_x, want.point_y, want.segment_end,
                                 want.is_last, m_point_x, m_point_y, m_segment_end,
                                 m_is_last);
                end
            end
        end
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
